// ----- sv/srsg_pkg.sv -----
// srsg_pkg: shared widths, codes and payload types of the stepper ramp step generator
// no dependencies; compiled before every other file of the block

package srsg_pkg;

	// field widths
	localparam int CMD_W      = 3;
	localparam int IDX_W      = 8;
	localparam int WORD_W     = 16;
	localparam int CNT_W      = 24;
	localparam int DLY_W      = 16;
	localparam int PW_W       = 8;
	localparam int POS_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// defaults and fixed values
	localparam int TABLE_DEPTH_DEF = 256;
	localparam logic [PW_W-1:0]  PULSE_TICKS   = PW_W'(8);
	localparam logic [DLY_W-1:0] SLOW_DLY_RST  = DLY_W'(65535);
	localparam logic [DLY_W-1:0] MIN_DLY_RST   = DLY_W'(1000);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// command codes on the input channel
	typedef enum logic [CMD_W-1:0] {
		CMD_STEP      = 3'd0,
		CMD_PULSE_END = 3'd1,
		CMD_LOAD_ACC  = 3'd2,
		CMD_LOAD_DEC  = 3'd3,
		CMD_START     = 3'd4
	} cmd_code_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_END  = 3'd0,
		REG_ACCEL_END  = 3'd1,
		REG_RUN_END    = 3'd2,
		REG_DECEL_END  = 3'd3,
		REG_MOVE_END   = 3'd4,
		REG_SLOW_DELAY = 3'd5,
		REG_FAST_DELAY = 3'd6,
		REG_REVERSE    = 3'd7
	} cfg_reg_t;

	// decoded operation carried through the queue
	typedef enum logic [2:0] {
		OP_NOP,
		OP_STEP,
		OP_PULSE_END,
		OP_LOAD_ACC,
		OP_LOAD_DEC,
		OP_START
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  table_index;
		logic [WORD_W-1:0] table_word;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] start_end;
		logic [CNT_W-1:0] accel_end;
		logic [CNT_W-1:0] run_end;
		logic [CNT_W-1:0] decel_end;
		logic [CNT_W-1:0] move_end;
		logic [DLY_W-1:0] slow_delay;
		logic [DLY_W-1:0] fast_delay;
		logic             reverse;
	} cfg_t;

	typedef struct packed {
		logic                    step_level;
		logic [DLY_W-1:0]        next_delay;
		logic [PW_W-1:0]         pulse_width;
		logic signed [POS_W-1:0] position;
		logic                    stopped;
	} res_t;

	// queue head as seen by the back part
	typedef struct packed {
		logic  vld;
		item_t item;
	} head_t;

endpackage

// ----- sv/srsg_cmd_if.sv -----
// srsg_cmd_if: command channel of the step generator, valid/ready with the command fields
// depends on srsg_pkg

interface srsg_cmd_if
	import srsg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [IDX_W-1:0]  table_index;
	logic [WORD_W-1:0] table_word;

	modport source(output valid, output command, output table_index, output table_word,
		input ready);
	modport sink(input valid, input command, input table_index, input table_word,
		output ready);
endinterface

// ----- sv/srsg_res_if.sv -----
// srsg_res_if: result channel of the step generator, valid/ready with the result fields
// depends on srsg_pkg

interface srsg_res_if
	import srsg_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    step_level;
	logic [DLY_W-1:0]        next_delay;
	logic [PW_W-1:0]         pulse_width;
	logic signed [POS_W-1:0] position;
	logic                    stopped;

	modport source(output valid, output step_level, output next_delay, output pulse_width,
		output position, output stopped, input ready);
	modport sink(input valid, input step_level, input next_delay, input pulse_width,
		input position, input stopped, output ready);
endinterface

// ----- sv/srsg_cfg_if.sv -----
// srsg_cfg_if: register write channel, valid/ready with register index and write data
// depends on srsg_pkg

interface srsg_cfg_if
	import srsg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/srsg_front.sv -----
// srsg_front: takes command requests and classifies them into queue items
// depends on srsg_pkg and srsg_cmd_if

module srsg_front
	import srsg_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	srsg_cmd_if.sink cmd,
	input  logic     q_full,
	output logic     push_vld,
	output item_t    push_item
);

	logic wr_in_range;

	// accept whenever the queue has room
	assign cmd.ready = !q_full;
	assign push_vld  = cmd.valid && !q_full;

	// table writes past the depth are dropped here
	assign wr_in_range = 32'(cmd.table_index) < 32'(TABLE_DEPTH);

	// command decode
	always_comb begin
		push_item.table_index = cmd.table_index;
		push_item.table_word  = cmd.table_word;
		unique case (cmd.command)
			CMD_STEP:      push_item.op = OP_STEP;
			CMD_PULSE_END: push_item.op = OP_PULSE_END;
			CMD_LOAD_ACC:  push_item.op = wr_in_range ? OP_LOAD_ACC : OP_NOP;
			CMD_LOAD_DEC:  push_item.op = wr_in_range ? OP_LOAD_DEC : OP_NOP;
			CMD_START:     push_item.op = OP_START;
			default:       push_item.op = OP_NOP;
		endcase
	end

endmodule

// ----- sv/srsg_queue.sv -----
// srsg_queue: short fifo that decouples the command front from the execution back
// depends on srsg_pkg

module srsg_queue
	import srsg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_vld,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output head_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	item_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_pop;

	assign full      = count_q == CNT_QW'(QUEUE_DEPTH);
	assign head.vld  = count_q != '0;
	assign head.item = entry_q[rd_ptr_q];
	assign do_pop    = pop && head.vld;

	// storage
	always_ff @(posedge clk) begin
		if (push_vld) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_vld) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push_vld && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !push_vld) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// ----- sv/srsg_back.sv -----
// srsg_back: executes queued commands, holds axis state, ramp tables and the result register
// depends on srsg_pkg and srsg_res_if

module srsg_back
	import srsg_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  head_t    head,
	output logic     pop,
	srsg_res_if.source res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [AW-1:0]    LAST_C  = AW'(TABLE_DEPTH - 1);

	// ramp tables
	logic [DLY_W-1:0] acc_mem [TABLE_DEPTH];
	logic [DLY_W-1:0] dec_mem [TABLE_DEPTH];
	logic [DLY_W-1:0] acc_rd_q;
	logic [DLY_W-1:0] dec_rd_q;

	// axis state
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [DLY_W-1:0]        dly_q, dly_d;
	logic signed [POS_W-1:0] pos_q, pos_d;
	logic                    run_q, run_d;
	logic                    pin_q, pin_d;

	// result register
	logic res_vld_q;
	res_t res_q, res_d;

	logic             exec;
	logic             wr_acc, wr_dec;
	logic [AW-1:0]    wr_addr;
	logic [CNT_W-1:0] off_acc, off_dec;
	logic [AW-1:0]    acc_addr, dec_addr;
	logic [DLY_W-1:0] pick;

	// execute the head when the result register is free or being drained
	assign exec = head.vld && (!res_vld_q || res.ready);
	assign pop  = exec;

	assign wr_addr = AW'(head.item.table_index);

	// delay for the segment the current count lies in
	always_comb begin
		priority if (cnt_q < cfg.start_end) begin
			pick = cfg.slow_delay;
		end else if (cnt_q < cfg.accel_end) begin
			pick = acc_rd_q;
		end else if (cnt_q < cfg.run_end) begin
			pick = cfg.fast_delay;
		end else if (cnt_q < cfg.decel_end) begin
			pick = dec_rd_q;
		end else begin
			pick = cfg.slow_delay;
		end
	end

	// command execution and next state
	always_comb begin
		cnt_d  = cnt_q;
		dly_d  = dly_q;
		pos_d  = pos_q;
		run_d  = run_q;
		pin_d  = pin_q;
		wr_acc = 1'b0;
		wr_dec = 1'b0;
		res_d.next_delay  = '0;
		res_d.pulse_width = '0;
		res_d.stopped     = 1'b0;
		if (exec) begin
			unique case (head.item.op)
				OP_STEP: begin
					if (run_q && cnt_q < cfg.move_end) begin
						pin_d = 1'b1;
						res_d.next_delay  = dly_q;
						res_d.pulse_width = PULSE_TICKS;
						pos_d = cfg.reverse ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
						dly_d = pick;
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						run_d = 1'b0;
						res_d.stopped = 1'b1;
					end
				end
				OP_PULSE_END: pin_d = 1'b0;
				OP_LOAD_ACC:  wr_acc = 1'b1;
				OP_LOAD_DEC:  wr_dec = 1'b1;
				OP_START: begin
					cnt_d = '0;
					dly_d = cfg.slow_delay;
					run_d = 1'b1;
				end
				OP_NOP: ;
				default: ;
			endcase
		end
		res_d.step_level = pin_d;
		res_d.position   = pos_d;
	end

	// table addresses follow the next count so read data lines up with it
	always_comb begin
		off_acc  = cnt_d - cfg.start_end;
		off_dec  = cnt_d - cfg.run_end;
		acc_addr = (off_acc >= DEPTH_C) ? LAST_C : off_acc[AW-1:0];
		dec_addr = (off_dec >= DEPTH_C) ? LAST_C : off_dec[AW-1:0];
	end

	// table write ports
	always_ff @(posedge clk) begin
		if (wr_acc) begin
			acc_mem[wr_addr] <= head.item.table_word;
		end
		if (wr_dec) begin
			dec_mem[wr_addr] <= head.item.table_word;
		end
	end

	// table read ports, new write data passed through on an address match
	always_ff @(posedge clk) begin
		if (wr_acc && wr_addr == acc_addr) begin
			acc_rd_q <= head.item.table_word;
		end else begin
			acc_rd_q <= acc_mem[acc_addr];
		end
		if (wr_dec && wr_addr == dec_addr) begin
			dec_rd_q <= head.item.table_word;
		end else begin
			dec_rd_q <= dec_mem[dec_addr];
		end
	end

	// axis state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dly_q <= '0;
			pos_q <= '0;
			run_q <= 1'b0;
			pin_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			dly_q <= dly_d;
			pos_q <= pos_d;
			run_q <= run_d;
			pin_q <= pin_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (exec) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = res_vld_q;
	assign res.step_level  = res_q.step_level;
	assign res.next_delay  = res_q.next_delay;
	assign res.pulse_width = res_q.pulse_width;
	assign res.position    = res_q.position;
	assign res.stopped     = res_q.stopped;

endmodule

// ----- sv/stepper_ramp_step_generator.sv -----
// stepper_ramp_step_generator: top level of the trapezoidal step generator for one axis
// depends on srsg_pkg, the three channel interfaces, srsg_front, srsg_queue and srsg_back
//
//   channel  dir  carries
//   cmd      in   command, table_index, table_word
//   res      out  step_level, next_delay, pulse_width, position, stopped
//   cfg      in   index, data (register writes, always ready)
//
// a command is written into the queue at its accepting edge, executed from the queue head
// when the result register is free or draining, its result registered as it executes; one
// command a cycle is sustained while res.ready is high. a step reads both ramp tables from
// registers indexed by its count. reset clears the axis state, queue and result valid; ramp
// tables hold nothing until loaded. a stalled result keeps the back part waiting; the
// two-entry queue then fills before cmd.ready drops.

module stepper_ramp_step_generator
	import srsg_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	srsg_cmd_if.sink   cmd,
	srsg_res_if.source res,
	srsg_cfg_if.sink   cfg
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  push_vld;
	item_t push_item;
	logic  pop;
	head_t head;

	// register file writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_end  <= '0;
			cfg_q.accel_end  <= '0;
			cfg_q.run_end    <= '0;
			cfg_q.decel_end  <= '0;
			cfg_q.move_end   <= '0;
			cfg_q.slow_delay <= SLOW_DLY_RST;
			cfg_q.fast_delay <= MIN_DLY_RST;
			cfg_q.reverse    <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_END:  cfg_q.start_end  <= cfg.data;
				REG_ACCEL_END:  cfg_q.accel_end  <= cfg.data;
				REG_RUN_END:    cfg_q.run_end    <= cfg.data;
				REG_DECEL_END:  cfg_q.decel_end  <= cfg.data;
				REG_MOVE_END:   cfg_q.move_end   <= cfg.data;
				REG_SLOW_DELAY: cfg_q.slow_delay <= cfg.data[DLY_W-1:0];
				REG_FAST_DELAY: cfg_q.fast_delay <= cfg.data[DLY_W-1:0];
				REG_REVERSE:    cfg_q.reverse    <= cfg.data[0];
			endcase
		end
	end

	srsg_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.cmd      (cmd),
		.q_full   (q_full),
		.push_vld (push_vld),
		.push_item(push_item)
	);

	srsg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (push_vld),
		.push_item(push_item),
		.pop      (pop),
		.full     (q_full),
		.head     (head)
	);

	srsg_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.head  (head),
		.pop   (pop),
		.res   (res)
	);

	// an accepted request is waiting in the queue on the next cycle
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> head.vld)
		else $error("accepted request missing from queue");

	// a pulse is only reported with the pin high and the move still going
	a_pulse_level: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.pulse_width != '0 |-> res.step_level && !res.stopped)
		else $error("pulse reported without step level");

	// a stop report carries no delay and no pulse
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.stopped |-> res.next_delay == '0 && res.pulse_width == '0)
		else $error("stop report carries a step");

endmodule

// ----- verif/stepper_ramp_step_generator_test.sv -----
// stepper_ramp_step_generator_test: self-checking bench for the trapezoidal step generator
// needs srsg_pkg, the cmd/res/cfg channel interfaces and the stepper_ramp_step_generator rtl
// a scoreboard class predicts every result; tasks drive requests with random gaps and stalls

module stepper_ramp_step_generator_test
	import srsg_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int TAB_AW = $clog2(DEPTH);
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [DLY_W-1:0] DLY_MAX = '1;

	// predicts the axis state and the result of every accepted request
	class ramp_scoreboard;
		logic [CNT_W-1:0] start_end, accel_end, run_end, decel_end, move_end;
		logic [DLY_W-1:0] slow_delay, fast_delay;
		logic reverse;
		logic [CNT_W-1:0] steps_done;
		logic [DLY_W-1:0] cur_delay;
		logic [POS_W-1:0] axis_pos;
		bit running;
		bit pin;
		logic [WORD_W-1:0] accel_tab [DEPTH];
		logic [WORD_W-1:0] decel_tab [DEPTH];
		res_t due_results[$];
		int errors;

		function new();
			start_end = '0;
			accel_end = '0;
			run_end = '0;
			decel_end = '0;
			move_end = '0;
			slow_delay = SLOW_DLY_RST;
			fast_delay = MIN_DLY_RST;
			reverse = 1'b0;
			steps_done = '0;
			cur_delay = '0;
			axis_pos = '0;
			running = 0;
			pin = 0;
			errors = 0;
			foreach (accel_tab[i]) begin
				accel_tab[i] = '0;
				decel_tab[i] = '0;
			end
		endfunction

		function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
			case (r)
				REG_START_END:  start_end = d[CNT_W-1:0];
				REG_ACCEL_END:  accel_end = d[CNT_W-1:0];
				REG_RUN_END:    run_end = d[CNT_W-1:0];
				REG_DECEL_END:  decel_end = d[CNT_W-1:0];
				REG_MOVE_END:   move_end = d[CNT_W-1:0];
				REG_SLOW_DELAY: slow_delay = d[DLY_W-1:0];
				REG_FAST_DELAY: fast_delay = d[DLY_W-1:0];
				REG_REVERSE:    reverse = d[0];
				default: ;
			endcase
		endfunction

		// delay that follows the step at count cnt, by segment
		function logic [DLY_W-1:0] ramp_delay(logic [CNT_W-1:0] cnt);
			logic [CNT_W-1:0] off;
			logic [TAB_AW-1:0] ti;
			if (cnt < start_end)
				return slow_delay;
			if (cnt < accel_end) begin
				off = cnt - start_end;
				ti = (off >= CNT_W'(DEPTH)) ? TAB_AW'(DEPTH - 1) : off[TAB_AW-1:0];
				return accel_tab[ti];
			end
			if (cnt < run_end)
				return fast_delay;
			if (cnt < decel_end) begin
				off = cnt - run_end;
				ti = (off >= CNT_W'(DEPTH)) ? TAB_AW'(DEPTH - 1) : off[TAB_AW-1:0];
				return decel_tab[ti];
			end
			return slow_delay;
		endfunction

		function void note_command(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
				logic [WORD_W-1:0] w);
			res_t r;
			r.next_delay = '0;
			r.pulse_width = '0;
			r.stopped = 1'b0;
			case (c)
				CMD_STEP: begin
					if (running && steps_done < move_end) begin
						pin = 1;
						r.next_delay = cur_delay;
						r.pulse_width = PULSE_TICKS;
						axis_pos = reverse ? axis_pos - POS_W'(1) : axis_pos + POS_W'(1);
						cur_delay = ramp_delay(steps_done);
						steps_done = steps_done + CNT_W'(1);
					end else begin
						running = 0;
						r.stopped = 1'b1;
					end
				end
				CMD_PULSE_END: pin = 0;
				CMD_LOAD_ACC: if (idx < DEPTH) accel_tab[idx] = w;
				CMD_LOAD_DEC: if (idx < DEPTH) decel_tab[idx] = w;
				CMD_START: begin
					steps_done = '0;
					cur_delay = slow_delay;
					running = 1;
				end
				default: ;
			endcase
			r.step_level = pin;
			r.position = axis_pos;
			due_results.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (due_results.size() == 0) begin
				$error("result with no request waiting");
				errors++;
				return;
			end
			exp = due_results.pop_front();
			if (got.step_level !== exp.step_level) begin
				$error("step_level expected %0d got %0d", exp.step_level, got.step_level);
				errors++;
			end
			if (got.next_delay !== exp.next_delay) begin
				$error("next_delay expected %0d got %0d", exp.next_delay, got.next_delay);
				errors++;
			end
			if (got.pulse_width !== exp.pulse_width) begin
				$error("pulse_width expected %0d got %0d", exp.pulse_width, got.pulse_width);
				errors++;
			end
			if (got.position !== exp.position) begin
				$error("position expected %0d got %0d", exp.position, got.position);
				errors++;
			end
			if (got.stopped !== exp.stopped) begin
				$error("stopped expected %0d got %0d", exp.stopped, got.stopped);
				errors++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit quiet;
	bit hold_off_req;
	int idle_cycles;
	ramp_scoreboard sb = new();

	srsg_cmd_if cmd_ch();
	srsg_res_if res_ch();
	srsg_cfg_if cfg_ch();

	stepper_ramp_step_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// random idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		res_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				n = idle_len();
				if (n > 0) begin
					res_ch.ready <= 1'b0;
					repeat (n) @(negedge clk);
				end
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.step_level = res_ch.step_level;
			got.next_delay = res_ch.next_delay;
			got.pulse_width = res_ch.pulse_width;
			got.position = res_ch.position;
			got.stopped = res_ch.stopped;
			sb.check_result(got);
		end
	end

	// watchdog on cycles with no request moving anywhere
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one command request; called at a falling edge, returns at one
	task automatic drive_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] w);
		int gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.table_index <= idx;
		cmd_ch.table_word <= w;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(c, idx, w);
		@(negedge clk);
		gap = idle_len();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drive_rand(input logic [CMD_W-1:0] c);
		drive_cmd(c, IDX_W'($urandom_range(0, 255)), WORD_W'($urandom_range(0, 65535)));
	endtask

	// one register write request
	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(r, d);
		@(negedge clk);
	endtask

	task automatic write_profile(input logic [CNT_W-1:0] s, a, rn, d, m,
			input logic [DLY_W-1:0] sd, md, input logic rev);
		write_reg(REG_START_END, s);
		write_reg(REG_ACCEL_END, a);
		write_reg(REG_RUN_END, rn);
		write_reg(REG_DECEL_END, d);
		write_reg(REG_MOVE_END, m);
		write_reg(REG_SLOW_DELAY, CFG_DATA_W'(sd));
		write_reg(REG_FAST_DELAY, CFG_DATA_W'(md));
		write_reg(REG_REVERSE, CFG_DATA_W'(rev));
		cfg_ch.valid <= 1'b0;
	endtask

	// stop offering and wait for every predicted result
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// random moves: start when idle, then steps and pulse ends with some noise
	task automatic run_phase(input int n_items, input int step_pct, input int restart_pct,
			input bit press);
		int r;
		for (int k = 0; k < n_items; k++) begin
			if (press && k == n_items / 4)
				hold_off_req = 1;
			r = $urandom_range(0, 99);
			if (!sb.running && $urandom_range(0, 1))
				drive_rand(CMD_START);
			else if (r < step_pct)
				drive_rand(CMD_STEP);
			else if (r < step_pct + 25)
				drive_rand(CMD_PULSE_END);
			else if (r < step_pct + 25 + restart_pct)
				drive_rand(CMD_START);
			else if (r < 97)
				drive_rand($urandom_range(0, 1) ? CMD_LOAD_ACC : CMD_LOAD_DEC);
			else
				drive_rand(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
		end
		wait_drained();
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.table_index = '0;
		cmd_ch.table_word = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		quiet = 0;
		hold_off_req = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// short profile that visits every segment in a dozen steps
		write_profile(2, 5, 7, 10, 12, 300, 50, 1'b0);

		// load both tables completely so no step reads an empty entry
		for (int i = 0; i < DEPTH; i++)
			drive_cmd(CMD_LOAD_ACC, IDX_W'(i), WORD_W'($urandom_range(0, 65535)));
		for (int i = 0; i < DEPTH; i++)
			drive_cmd(CMD_LOAD_DEC, IDX_W'(i), WORD_W'($urandom_range(0, 65535)));

		// directed: step while idle, table word extremes, unused codes, restart, move end
		drive_cmd(CMD_STEP, 8'h00, 16'h0000);
		drive_cmd(CMD_PULSE_END, 8'hff, 16'hffff);
		drive_cmd(CMD_LOAD_ACC, 8'h00, 16'h0000);
		drive_cmd(CMD_LOAD_ACC, 8'hff, 16'hffff);
		drive_cmd(CMD_LOAD_DEC, 8'h00, 16'hffff);
		drive_cmd(CMD_LOAD_DEC, 8'hff, 16'h0000);
		drive_cmd(CMD_UNUSED_LO, 8'h00, 16'h0000);
		drive_cmd(CMD_UNUSED_HI, 8'hff, 16'hffff);
		drive_cmd(CMD_START, 8'h00, 16'h0000);
		repeat (3) drive_cmd(CMD_STEP, 8'h00, 16'h0000);
		drive_cmd(CMD_PULSE_END, 8'h00, 16'h0000);
		drive_cmd(CMD_START, 8'h00, 16'h0000);
		repeat (12) drive_cmd(CMD_STEP, 8'h00, 16'h0000);
		drive_cmd(CMD_PULSE_END, 8'h00, 16'h0000);
		drive_cmd(CMD_STEP, 8'h00, 16'h0000);
		wait_drained();

		// short random profiles, segment ends in any order
		repeat (6) begin
			write_profile(CNT_W'($urandom_range(0, 40)), CNT_W'($urandom_range(0, 40)),
				CNT_W'($urandom_range(0, 40)), CNT_W'($urandom_range(0, 40)),
				CNT_W'($urandom_range(0, 50)), DLY_W'($urandom_range(1, 65535)),
				DLY_W'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
			run_phase(80, 45, 6, 0);
		end

		// all ends zero, smallest delays: every step finds the move over
		write_profile(0, 0, 0, 0, 0, 1, 1, 1'b0);
		run_phase(50, 45, 6, 0);

		// everything at its maximum
		write_profile(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, DLY_MAX, DLY_MAX, 1'b1);
		run_phase(80, 50, 2, 0);

		// acceleration segment longer than the table, read index clamps
		write_profile(0, 270, 272, 274, 276, DLY_W'($urandom_range(1, 65535)),
			DLY_W'($urandom_range(1, 65535)), 1'b0);
		run_phase(420, 70, 0, 0);

		// deceleration segment longer than the table, no idling, receiver held off once
		write_profile(1, 1, 3, 275, 278, DLY_W'($urandom_range(1, 65535)),
			DLY_W'($urandom_range(1, 65535)), 1'b1);
		quiet = 1;
		run_phase(420, 70, 0, 1);
		quiet = 0;

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
